// ----- src/hsl_pkg.sv -----
// Shared types, character codes and verdict codes for the HTTP status-line checker.
package hsl_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [1:0] outcome_type;
   typedef logic [9:0] code_type;
   typedef logic [2:0] phase_type;
   typedef logic [1:0] count_type;
   typedef logic [1:0] progress_type;

   // parse phases
   localparam phase_type PHASE_SEEK   = 3'd0;
   localparam phase_type PHASE_SKIP   = 3'd1;
   localparam phase_type PHASE_DIGITS = 3'd2;
   localparam phase_type PHASE_GOOD   = 3'd3;
   localparam phase_type PHASE_BAD    = 3'd4;

   // terminator match progress
   localparam progress_type PROG_NONE = 2'd0;
   localparam progress_type PROG_CR   = 2'd1;
   localparam progress_type PROG_CRLF = 2'd2;
   localparam progress_type PROG_CRLFCR = 2'd3;

   localparam byte_type CH_NUL   = 8'h00;
   localparam byte_type CH_LF    = 8'h0A;
   localparam byte_type CH_CR    = 8'h0D;
   localparam byte_type CH_SPACE = 8'h20;
   localparam byte_type CH_ZERO  = 8'h30;
   localparam byte_type CH_NINE  = 8'h39;

   localparam count_type DIGITS_MAX = 2'd3;

   localparam code_type CODE_MIN   = 10'd100;
   localparam code_type CODE_LIMIT = 10'd600;

   localparam outcome_type OUT_INCOMPLETE = 2'd0;
   localparam outcome_type OUT_VALID      = 2'd1;
   localparam outcome_type OUT_MALFORMED  = 2'd2;

   typedef struct packed {
      logic        present;
      outcome_type outcome;
      code_type    status_code;
   } verdict_type;

endpackage

// ----- src/hsl_if.sv -----
// Handshake channels for response bytes and verdict words.
interface hsl_req_if;
   import hsl_pkg::*;

   logic     valid;
   logic     ready;
   byte_type data_byte;
   logic     first_byte;
   logic     buffer_end;

   modport source (output valid, output data_byte, output first_byte, output buffer_end,
                   input ready);
   modport sink   (input valid, input data_byte, input first_byte, input buffer_end,
                   output ready);
endinterface

interface hsl_rsp_if;
   import hsl_pkg::*;

   logic        valid;
   logic        ready;
   outcome_type outcome;
   code_type    status_code;

   modport source (output valid, output outcome, output status_code, input ready);
   modport sink   (input valid, input outcome, input status_code, output ready);
endinterface

// ----- src/http_status_line_checker_unit.sv -----
// Path: an accepted byte waits in the input register; as it advances, the parser updates its
//   state and any verdict word for the byte is loaded into the rsp register.
// Throughput: one byte per cycle while rsp is not stalled; the parse state updates as a byte
//   leaves the input register, which refills as it empties; bytes wait only on an rsp stall.
// Stalls on rsp hold the input register only when a verdict word is still unread.
// Reset (synchronous): clears the parse state and empties both registers.
module http_status_line_checker_unit (
   input logic clock,
   input logic reset,
   hsl_req_if.sink   req_chan,
   hsl_rsp_if.source rsp_chan
);
   import hsl_pkg::*;

   logic        in_valid_ff, in_valid_in;
   byte_type    in_byte_ff;
   logic        in_first_ff;
   logic        in_end_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   outcome_type rsp_outcome_ff;
   code_type    rsp_code_ff;

   logic        advance;
   logic        req_take;
   verdict_type verdict;

   assign advance  = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = (advance && verdict.present) ? 1'b1
                       : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   hsl_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .fire       (advance),
      .data_byte  (in_byte_ff),
      .first_byte (in_first_ff),
      .buffer_end (in_end_ff),
      .verdict    (verdict)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff  <= req_chan.data_byte;
         in_first_ff <= req_chan.first_byte;
         in_end_ff   <= req_chan.buffer_end;
      end
      if (advance && verdict.present) begin
         rsp_outcome_ff <= verdict.outcome;
         rsp_code_ff    <= verdict.status_code;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.outcome     = rsp_outcome_ff;
   assign rsp_chan.status_code = rsp_code_ff;

   // a valid verdict always carries a code in range
   a_valid_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_outcome_ff == OUT_VALID)
         |-> (rsp_code_ff >= CODE_MIN) && (rsp_code_ff < CODE_LIMIT))
      else $error("valid verdict with out-of-range status code");

   a_other_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_outcome_ff != OUT_VALID) |-> (rsp_code_ff == '0))
      else $error("non-valid verdict with non-zero status code");

   a_known_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_outcome_ff == OUT_INCOMPLETE) || (rsp_outcome_ff == OUT_VALID)
                       || (rsp_outcome_ff == OUT_MALFORMED))
      else $error("verdict outcome code out of range");

   // a held byte stays put until the verdict register frees up
   a_hold_byte: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_first_ff))
      else $error("input word lost while verdict register stalled");

endmodule

// ----- src/hsl_parser.sv -----
// Per-byte parse state, terminator match and verdict decision.
module hsl_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  hsl_pkg::byte_type    data_byte,
   input  logic                 first_byte,
   input  logic                 buffer_end,
   output hsl_pkg::verdict_type verdict
);
   import hsl_pkg::*;

   phase_type    phase_ff, phase_in;
   count_type    count_ff, count_in;
   code_type     acc_ff, acc_in;
   progress_type prog_ff, prog_in;
   logic         sent_ff, sent_in;

   // state after an optional new-response clear
   phase_type    phase_cur;
   count_type    count_cur;
   code_type     acc_cur;
   progress_type prog_cur;
   logic         sent_cur;

   phase_type    phase_p;
   count_type    count_p;
   code_type     acc_p;
   progress_type prog_p;
   logic         term;
   logic         is_space;
   logic         is_digit;
   logic         take_digits;
   logic [13:0]  mac_wide;
   code_type     acc_mac;
   logic         code_ok;

   assign phase_cur = first_byte ? PHASE_SEEK : phase_ff;
   assign count_cur = first_byte ? '0 : count_ff;
   assign acc_cur   = first_byte ? '0 : acc_ff;
   assign prog_cur  = first_byte ? PROG_NONE : prog_ff;
   assign sent_cur  = first_byte ? 1'b0 : sent_ff;

   assign is_space    = (data_byte == CH_SPACE);
   assign is_digit    = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
   assign take_digits = (phase_cur == PHASE_DIGITS) || ((phase_cur == PHASE_SKIP) && !is_space);

   // acc * 10 + digit
   assign mac_wide = 14'({acc_cur, 3'b000}) + 14'({acc_cur, 1'b0})
                   + 14'(data_byte - CH_ZERO);
   assign acc_mac  = mac_wide[9:0];

   always_comb begin
      phase_p = phase_cur;
      count_p = count_cur;
      acc_p   = acc_cur;
      if (phase_cur == PHASE_SEEK) begin
         if (is_space) phase_p = PHASE_SKIP;
      end else if (take_digits) begin
         if (is_digit) begin
            if (count_cur == DIGITS_MAX) begin
               phase_p = PHASE_BAD;
            end else begin
               acc_p   = acc_mac;
               count_p = count_cur + 2'd1;
               phase_p = PHASE_DIGITS;
            end
         end else if (is_space) begin
            phase_p = (count_cur == '0) ? PHASE_BAD : PHASE_GOOD;
         end else begin
            phase_p = PHASE_BAD;
         end
      end
   end

   always_comb begin
      term   = 1'b0;
      prog_p = PROG_NONE;
      case (prog_cur)
         PROG_NONE: begin
            prog_p = (data_byte == CH_CR) ? PROG_CR : PROG_NONE;
         end
         PROG_CR: begin
            if (data_byte == CH_LF)      prog_p = PROG_CRLF;
            else if (data_byte == CH_CR) prog_p = PROG_CR;
         end
         PROG_CRLF: begin
            prog_p = (data_byte == CH_CR) ? PROG_CRLFCR : PROG_NONE;
         end
         default: begin
            if (data_byte == CH_LF) begin
               term = 1'b1;
            end else if (data_byte == CH_CR) begin
               prog_p = PROG_CR;
            end
         end
      endcase
   end

   assign code_ok = (phase_p == PHASE_GOOD) && (acc_p >= CODE_MIN) && (acc_p < CODE_LIMIT);

   always_comb begin
      phase_in = phase_cur;
      count_in = count_cur;
      acc_in   = acc_cur;
      prog_in  = prog_cur;
      sent_in  = sent_cur;
      verdict  = '{present: 1'b0, outcome: OUT_INCOMPLETE, status_code: '0};
      if (!sent_cur) begin
         if (data_byte == CH_NUL) begin
            // end of string: give up on this response
            sent_in         = 1'b1;
            verdict.present = 1'b1;
         end else begin
            phase_in = phase_p;
            count_in = count_p;
            acc_in   = acc_p;
            prog_in  = prog_p;
            if (term) begin
               sent_in         = 1'b1;
               verdict.present = 1'b1;
               if (code_ok) begin
                  verdict.outcome     = OUT_VALID;
                  verdict.status_code = acc_p;
               end else begin
                  verdict.outcome = OUT_MALFORMED;
               end
            end else if (buffer_end) begin
               verdict.present = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_SEEK;
         count_ff <= '0;
         acc_ff   <= '0;
         prog_ff  <= PROG_NONE;
         sent_ff  <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         acc_ff   <= acc_in;
         prog_ff  <= prog_in;
         sent_ff  <= sent_in;
      end
   end

endmodule
